/* hdl/hse_pkg.sv */
`timescale 1ns / 1ps
package hse_pkg;
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;
endpackage

/* hdl/hse_ram.sv */
`timescale 1ns / 1ps
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/heap_sort_engine.sv */
`timescale 1ns / 1ps
// Heapsort engine. Values arrive one request per cycle and are stored in a
// 64-entry single-port-read RAM; the request flagged last_of_set starts the
// sort, and requests beyond 64 are dropped and reported through overflowed on
// every result of the set. While the block sorts and emits, it accepts no
// input. Sorting runs a sift-down sequencer around the RAM's single read
// port: each heap level reads the left child, reads the right child, then
// compares and writes back (S_CHK, S_LEFT, S_RIGHT); each heap-build sift
// starts by reading its node (S_BLD_RD, S_BLD_V) and each root swap reads the
// root and the last entry and writes the swap (S_SRT_RD0, S_SRT_RDL,
// S_SRT_SWAP). Each sorted result is read, registered and held until
// out_ready, values leaving in ascending order with final_res on the last.
module heap_sort_engine
  import hse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  input  logic               last_of_set,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sorted_value,
  output logic               final_res,
  output logic               overflowed
);
  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_BLD_RD   = 4'd1;
  localparam logic [3:0] S_BLD_V    = 4'd2;
  localparam logic [3:0] S_CHK      = 4'd3;
  localparam logic [3:0] S_LEFT     = 4'd4;
  localparam logic [3:0] S_RIGHT    = 4'd5;
  localparam logic [3:0] S_SRT_RD0  = 4'd6;
  localparam logic [3:0] S_SRT_RDL  = 4'd7;
  localparam logic [3:0] S_SRT_SWAP = 4'd8;
  localparam logic [3:0] S_EMIT_RD  = 4'd9;
  localparam logic [3:0] S_EMIT_LD  = 4'd10;
  localparam logic [3:0] S_EMIT_OUT = 4'd11;

  logic [3:0] state;
  cnt_t       count;
  logic       dropped;
  cnt_t       hlen;
  idx_t       node;
  idx_t       bld_idx;
  idx_t       k;
  logic       sort_phase;
  data_t      v;
  data_t      lval;

  logic       we;
  idx_t       waddr;
  data_t      wdata;
  idx_t       raddr;
  data_t      rdata;

  logic [CNT_W:0] left_idx;
  logic [CNT_W:0] right_idx;
  logic           left_ok;
  logic           right_ok;
  logic           l_gt_v;
  logic           lval_gt_v;
  data_t          bigval;
  logic           r_gt;
  logic           has_room;
  cnt_t           n_final;
  logic           sift_done;
  idx_t           hlen_m1;

  hse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign left_idx  = {1'b0, CNT_W'({node, 1'b1})};
  assign right_idx = left_idx + (CNT_W + 1)'(1);
  assign left_ok   = left_idx < {1'b0, hlen};
  assign right_ok  = right_idx < {1'b0, hlen};
  assign l_gt_v    = rdata > v;
  assign lval_gt_v = lval > v;
  assign bigval    = lval_gt_v ? lval : v;
  assign r_gt      = rdata > bigval;
  assign has_room  = count < CNT_W'(CAPACITY);
  assign n_final   = has_room ? count + CNT_W'(1) : count;
  assign hlen_m1   = IDX_W'(hlen - CNT_W'(1));

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EMIT_OUT);

  always_comb begin
    sift_done = 1'b0;
    unique case (state)
      S_CHK:   sift_done = !left_ok;
      S_LEFT:  sift_done = !right_ok && !l_gt_v;
      S_RIGHT: sift_done = !r_gt && !lval_gt_v;
      default: sift_done = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = v;
    raddr = node;
    unique case (state)
      S_LOAD: begin
        we    = in_valid && has_room;
        waddr = count[IDX_W-1:0];
        wdata = value;
      end
      S_BLD_RD: begin
        raddr = bld_idx;
      end
      S_CHK: begin
        if (!left_ok) begin
          we = 1'b1;
        end else begin
          raddr = left_idx[IDX_W-1:0];
        end
      end
      S_LEFT: begin
        if (right_ok) begin
          raddr = right_idx[IDX_W-1:0];
        end else begin
          we    = 1'b1;
          wdata = l_gt_v ? rdata : v;
        end
      end
      S_RIGHT: begin
        we    = 1'b1;
        wdata = r_gt ? rdata : bigval;
      end
      S_SRT_RD0: begin
        raddr = '0;
      end
      S_SRT_RDL: begin
        raddr = hlen_m1;
      end
      S_SRT_SWAP: begin
        we    = 1'b1;
        waddr = hlen_m1;
        wdata = lval;
      end
      S_EMIT_RD: begin
        raddr = k;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      dropped    <= 1'b0;
      sort_phase <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last_of_set) begin
              hlen       <= n_final;
              bld_idx    <= IDX_W'(n_final >> 1);
              sort_phase <= 1'b0;
              k          <= '0;
              state      <= S_BLD_RD;
            end
          end
        end
        S_BLD_RD: begin
          state <= S_BLD_V;
        end
        S_BLD_V: begin
          v     <= rdata;
          node  <= bld_idx;
          state <= S_CHK;
        end
        S_CHK: begin
          if (left_ok) begin
            state <= S_LEFT;
          end
        end
        S_LEFT: begin
          lval <= rdata;
          if (right_ok) begin
            state <= S_RIGHT;
          end else if (l_gt_v) begin
            node  <= left_idx[IDX_W-1:0];
            state <= S_CHK;
          end
        end
        S_RIGHT: begin
          if (r_gt) begin
            node  <= right_idx[IDX_W-1:0];
            state <= S_CHK;
          end else if (lval_gt_v) begin
            node  <= left_idx[IDX_W-1:0];
            state <= S_CHK;
          end
        end
        S_SRT_RD0: begin
          state <= S_SRT_RDL;
        end
        S_SRT_RDL: begin
          lval  <= rdata;
          state <= S_SRT_SWAP;
        end
        S_SRT_SWAP: begin
          v     <= rdata;
          node  <= '0;
          hlen  <= hlen - CNT_W'(1);
          state <= S_CHK;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          sorted_value <= rdata;
          final_res    <= (CNT_W'(k) + CNT_W'(1)) == count;
          overflowed   <= dropped;
          state        <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_ready) begin
            if (final_res) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase

      if (sift_done) begin
        if (!sort_phase) begin
          if (bld_idx == '0) begin
            sort_phase <= 1'b1;
            hlen       <= count;
            state      <= (count > CNT_W'(1)) ? S_SRT_RD0 : S_EMIT_RD;
          end else begin
            bld_idx <= bld_idx - IDX_W'(1);
            state   <= S_BLD_RD;
          end
        end else begin
          state <= (hlen > CNT_W'(1)) ? S_SRT_RD0 : S_EMIT_RD;
        end
      end
    end
  end
endmodule
